// ----- rtl/set_assoc_cache_tag_controller_macros.svh -----
// Assertion macros for the cache tag controller; included by sactc_ctrl.
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define SACTC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sactc assertion failed");
// Expression must never be true out of reset.
`define SACTC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("sactc forbidden condition");
`else
`define SACTC_ASSERT(lbl, clk, rst_n, prop)
`define SACTC_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- rtl/sactc_pkg.sv -----
package sactc_pkg;

    localparam int OFFSET_BITS = 6;
    localparam int SET_BITS    = 12;
    localparam int WAY_BITS    = 4;
    localparam int ADDR_W      = 32;
    localparam int TAG_W       = ADDR_W - SET_BITS - OFFSET_BITS;
    localparam int NUM_SETS    = 1 << SET_BITS;
    localparam int NUM_WAYS    = 1 << WAY_BITS;
    localparam int LINE_BYTES  = 1 << OFFSET_BITS;
    localparam int MAX_BYTES   = 4;
    localparam int LFSR_W      = 16;
    localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;
    localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
    localparam logic [SET_BITS-1:0] SET_LAST = SET_BITS'(NUM_SETS - 1);

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] byte_address;
        logic [2:0]        byte_count;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   line_address;
        logic                hit;
        logic [WAY_BITS-1:0] way_used;
        logic                victim_dirty;
        logic [ADDR_W-1:0]   victim_address;
        logic                last;
    } rsp_t;

    // One set of the tag memory: all ways side by side
    typedef struct packed {
        logic [NUM_WAYS-1:0]             valid;
        logic [NUM_WAYS-1:0]             dirty;
        logic [NUM_WAYS-1:0][TAG_W-1:0]  tags;
    } row_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic load_req;
        logic clr_step;
        logic rd_issue;
        logic second;
        logic lookup;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic crosses;
        logic out_full;
    } sts_t;

endpackage

// ----- rtl/set_assoc_cache_tag_controller.sv -----
// Channel   Handshake          Payload
// s_        s_valid/s_ready    sactc_pkg::req_t (req_type, byte_address, byte_count)
// m_        m_valid/m_ready    sactc_pkg::rsp_t (line, hit, way, victim, last)
// cfg_      cfg_wr_en          cfg_wr_data: LFSR seed, loaded on write
//
// Each line lookup is a tag-memory row read (ST_READ), then compare and
// row write-back (ST_LOOKUP). An access covers one line, or two lines when it
// crosses a line boundary; the compare waits while the result register is full.
// After reset a clear sweep writes all 4096 tag-memory rows, one per cycle,
// before s_ready first rises.
module set_assoc_cache_tag_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sactc_pkg::req_t                   s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output sactc_pkg::rsp_t                   m_data,
    input  logic                              cfg_wr_en,
    input  logic [sactc_pkg::LFSR_W-1:0]      cfg_wr_data
);

    sactc_pkg::cmd_t cmd;
    sactc_pkg::sts_t sts;

    sactc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sactc_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .m_data      (m_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// ----- rtl/sactc_ctrl.sv -----
`include "set_assoc_cache_tag_controller_macros.svh"

module sactc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sactc_pkg::sts_t   sts,
    output sactc_pkg::cmd_t   cmd
);

    sactc_pkg::state_t state_reg, state_next;
    logic              second_reg, second_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sactc_pkg::ST_CLEAR;
            second_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        second_next  = second_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.second   = second_reg;
        unique case (state_reg)
            sactc_pkg::ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) begin
                    state_next = sactc_pkg::ST_IDLE;
                end
            end
            sactc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    second_next  = 1'b0;
                    state_next   = sactc_pkg::ST_READ;
                end
            end
            sactc_pkg::ST_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = sactc_pkg::ST_LOOKUP;
            end
            sactc_pkg::ST_LOOKUP: begin
                // hold until the result register can take a transfer
                if (!sts.out_full) begin
                    cmd.lookup = 1'b1;
                    if (sts.crosses && !second_reg) begin
                        second_next = 1'b1;
                        state_next  = sactc_pkg::ST_READ;
                    end else begin
                        state_next  = sactc_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = sactc_pkg::ST_CLEAR;
        endcase
    end

    `SACTC_ASSERT_NEVER(a_no_accept_in_clear, aclk, aresetn,
        (state_reg == sactc_pkg::ST_CLEAR) && s_ready)
    `SACTC_ASSERT_NEVER(a_no_lookup_when_full, aclk, aresetn,
        cmd.lookup && sts.out_full)
    `SACTC_ASSERT(a_second_line_follows, aclk, aresetn,
        (cmd.lookup && sts.crosses && !second_reg) |=>
        (state_reg == sactc_pkg::ST_READ) && second_reg)

endmodule

// ----- rtl/sactc_dp.sv -----
module sactc_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sactc_pkg::req_t                   s_data,
    output sactc_pkg::rsp_t                   m_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              cfg_wr_en,
    input  logic [sactc_pkg::LFSR_W-1:0]      cfg_wr_data,
    input  sactc_pkg::cmd_t                   cmd,
    output sactc_pkg::sts_t                   sts
);

    localparam int OFF  = sactc_pkg::OFFSET_BITS;
    localparam int SB   = sactc_pkg::SET_BITS;
    localparam int WB   = sactc_pkg::WAY_BITS;
    localparam int NW   = sactc_pkg::NUM_WAYS;
    localparam int AW   = sactc_pkg::ADDR_W;
    localparam int TW   = sactc_pkg::TAG_W;

    sactc_pkg::row_t mem [sactc_pkg::NUM_SETS];

    sactc_pkg::req_t              req_reg;
    sactc_pkg::row_t              row_reg;
    logic [AW-1:0]                line_reg;
    logic [SB-1:0]                clr_idx_reg;
    logic [sactc_pkg::LFSR_W-1:0] lfsr_reg, lfsr_next;
    sactc_pkg::rsp_t              m_data_reg;
    logic                         m_valid_reg;

    logic [AW-1:0]   line0, line1, cur_line;
    logic [2:0]      cnt_sat;
    logic [OFF:0]    end_pos;
    logic            crosses;
    logic [TW-1:0]   tag_cur;
    logic [SB-1:0]   set_cur;
    logic [NW-1:0]   hit_vec;
    logic            hit_found, inv_found;
    logic [WB-1:0]   hit_way, inv_way, way_sel;
    logic [sactc_pkg::LFSR_W-1:0] lfsr_step;
    logic            is_write, vict_dirty;
    sactc_pkg::row_t new_row;
    sactc_pkg::rsp_t rsp;

    // Address split and line crossing
    always_comb begin
        line0    = {req_reg.byte_address[AW-1:OFF], OFF'(0)};
        line1    = line0 + AW'(sactc_pkg::LINE_BYTES);
        cur_line = cmd.second ? line1 : line0;
        if (req_reg.byte_count == 3'd0) begin
            cnt_sat = 3'd1;
        end else if (req_reg.byte_count > 3'(sactc_pkg::MAX_BYTES)) begin
            cnt_sat = 3'(sactc_pkg::MAX_BYTES);
        end else begin
            cnt_sat = req_reg.byte_count;
        end
        end_pos = {1'b0, req_reg.byte_address[OFF-1:0]} + (OFF+1)'(cnt_sat);
        crosses = end_pos > (OFF+1)'(sactc_pkg::LINE_BYTES);
    end

    // Compare tags, choose the way, build the new row, response and next LFSR
    always_comb begin
        tag_cur   = line_reg[AW-1:OFF+SB];
        set_cur   = line_reg[OFF+SB-1:OFF];
        is_write  = req_reg.req_type == sactc_pkg::REQ_WRITE;
        hit_found = 1'b0;
        inv_found = 1'b0;
        hit_way   = '0;
        inv_way   = '0;
        for (int w = 0; w < NW; w++) begin
            hit_vec[w] = row_reg.valid[w] && (row_reg.tags[w] == tag_cur);
        end
        for (int w = NW - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_found = 1'b1;
                hit_way   = WB'(w);
            end
            if (!row_reg.valid[w]) begin
                inv_found = 1'b1;
                inv_way   = WB'(w);
            end
        end
        lfsr_step = {1'b0, lfsr_reg[sactc_pkg::LFSR_W-1:1]}
                  ^ (lfsr_reg[0] ? sactc_pkg::LFSR_TAPS : '0);
        if (hit_found) begin
            way_sel = hit_way;
        end else if (inv_found) begin
            way_sel = inv_way;
        end else begin
            way_sel = lfsr_step[WB-1:0];
        end
        vict_dirty = !hit_found && row_reg.valid[way_sel] && row_reg.dirty[way_sel];

        new_row = row_reg;
        if (hit_found) begin
            new_row.dirty[way_sel] = row_reg.dirty[way_sel] | is_write;
        end else begin
            new_row.tags[way_sel]  = tag_cur;
            new_row.valid[way_sel] = 1'b1;
            new_row.dirty[way_sel] = is_write;
        end

        rsp.line_address   = line_reg;
        rsp.hit            = hit_found;
        rsp.way_used       = way_sel;
        rsp.victim_dirty   = vict_dirty;
        rsp.victim_address = vict_dirty ? {row_reg.tags[way_sel], set_cur, OFF'(0)} : '0;
        rsp.last           = !crosses || cmd.second;

        lfsr_next = lfsr_reg;
        if (cfg_wr_en) begin
            lfsr_next = cfg_wr_data;
        end else if (cmd.lookup && !hit_found && !inv_found) begin
            lfsr_next = lfsr_step;
        end
    end

    // Tag memory: one read port, one write port
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            mem[clr_idx_reg] <= '0;
        end else if (cmd.lookup) begin
            mem[set_cur] <= new_row;
        end
        if (cmd.rd_issue) begin
            row_reg <= mem[cur_line[OFF+SB-1:OFF]];
        end
    end

    // Request, line and result data registers
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= s_data;
        end
        if (cmd.rd_issue) begin
            line_reg <= cur_line;
        end
        if (cmd.lookup) begin
            m_data_reg <= rsp;
        end
    end

    // Control registers: clear sweep, LFSR, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
            lfsr_reg    <= sactc_pkg::SEED_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_step) begin
                clr_idx_reg <= clr_idx_reg + SB'(1);
            end
            lfsr_reg <= lfsr_next;
            if (cmd.lookup) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.crosses  = crosses;
    assign sts.clr_done = clr_idx_reg == sactc_pkg::SET_LAST;
    assign sts.out_full = m_valid_reg && !m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

endmodule

// ----- tb/set_assoc_cache_tag_controller_tb.sv -----
module set_assoc_cache_tag_controller_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NUM_ENTRIES = sactc_pkg::NUM_SETS * sactc_pkg::NUM_WAYS;
    localparam int OFFB = sactc_pkg::OFFSET_BITS;
    localparam int SETB = sactc_pkg::SET_BITS;
    localparam int TAGW = sactc_pkg::TAG_W;
    localparam int LFW  = sactc_pkg::LFSR_W;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    sactc_pkg::req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    sactc_pkg::rsp_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [LFW-1:0] cfg_wr_data = '0;

    // Cache model state
    logic [TAGW-1:0] tag_mem [NUM_ENTRIES];
    logic valid_mem [NUM_ENTRIES];
    logic dirty_mem [NUM_ENTRIES];
    logic [LFW-1:0] victim_lfsr;

    sactc_pkg::req_t pending_reqs[$];
    sactc_pkg::rsp_t expected_rsps[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int s_gap = 0;
    int m_gap = 0;
    bit stim_done = 0;

    set_assoc_cache_tag_controller uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic void clear_cache(logic [LFW-1:0] seed);
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            tag_mem[i] = '0;
            valid_mem[i] = 1'b0;
            dirty_mem[i] = 1'b0;
        end
        victim_lfsr = seed;
    endfunction

    // Look up one line and update tags, marks and LFSR
    function automatic sactc_pkg::rsp_t lookup_line(logic [31:0] line, logic is_write,
                                                    logic fin);
        sactc_pkg::rsp_t r;
        logic [SETB-1:0] set;
        logic [TAGW-1:0] tag;
        int idx;
        int way;
        bit found;
        set = line[OFFB +: SETB];
        tag = line[31 -: TAGW];
        found = 0;
        way = 0;
        r = '0;
        for (int w = 0; w < sactc_pkg::NUM_WAYS; w++) begin
            idx = int'(set) * sactc_pkg::NUM_WAYS + w;
            if (!found && valid_mem[idx] && tag_mem[idx] == tag) begin
                found = 1;
                way = w;
            end
        end
        if (found) begin
            if (is_write) dirty_mem[int'(set) * sactc_pkg::NUM_WAYS + way] = 1'b1;
        end else begin
            way = sactc_pkg::NUM_WAYS;
            for (int w = sactc_pkg::NUM_WAYS - 1; w >= 0; w--)
                if (!valid_mem[int'(set) * sactc_pkg::NUM_WAYS + w]) way = w;
            if (way == sactc_pkg::NUM_WAYS) begin
                victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ sactc_pkg::LFSR_TAPS)
                                             : (victim_lfsr >> 1);
                way = int'(victim_lfsr[sactc_pkg::WAY_BITS-1:0]);
            end
            idx = int'(set) * sactc_pkg::NUM_WAYS + way;
            if (valid_mem[idx] && dirty_mem[idx]) begin
                r.victim_dirty = 1'b1;
                r.victim_address = {tag_mem[idx], set, {OFFB{1'b0}}};
            end
            tag_mem[idx] = tag;
            valid_mem[idx] = 1'b1;
            dirty_mem[idx] = is_write;
        end
        r.line_address = line;
        r.hit = found;
        r.way_used = way[sactc_pkg::WAY_BITS-1:0];
        r.last = fin;
        return r;
    endfunction

    function automatic void predict_access(sactc_pkg::req_t q);
        logic [31:0] line;
        int cnt;
        bit crosses;
        line = {q.byte_address[31:OFFB], {OFFB{1'b0}}};
        cnt = int'(q.byte_count);
        if (cnt == 0) cnt = 1;
        if (cnt > sactc_pkg::MAX_BYTES) cnt = sactc_pkg::MAX_BYTES;
        crosses = (int'(q.byte_address[OFFB-1:0]) + cnt) > sactc_pkg::LINE_BYTES;
        expected_rsps.push_back(lookup_line(line, q.req_type, !crosses));
        if (crosses)
            expected_rsps.push_back(lookup_line(line + 32'(sactc_pkg::LINE_BYTES),
                                                q.req_type, 1'b1));
    endfunction

    function automatic bit stim_busy();
        return aresetn && (s_valid || expected_rsps.size() > 0
                           || (pending_reqs.size() > 0 && !stim_done));
    endfunction

    // Driver: present queued requests with random gaps
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_access(s_data);
                s_gap <= pick_gap();
                if (pending_reqs.size() > 0 && pick_gap() == 0) begin
                    s_data <= pending_reqs.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end else if (!s_valid) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                end else if (pending_reqs.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= pending_reqs.pop_front();
                end
            end
        end
    end

    // Monitor: stall the result side at random and check each transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", m_data);
                end else begin
                    sactc_pkg::rsp_t e;
                    e = expected_rsps.pop_front();
                    if (e !== m_data) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", e, m_data);
                    end
                end
            end
            if (m_gap > 0) begin
                m_ready <= 1'b0;
                m_gap <= m_gap - 1;
            end else begin
                m_ready <= 1'b1;
                m_gap <= pick_gap();
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !stim_busy())
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic sactc_pkg::req_t make_req(logic t, logic [31:0] a, logic [2:0] c);
        sactc_pkg::req_t q;
        q.req_type = t;
        q.byte_address = a;
        q.byte_count = c;
        return q;
    endfunction

    // Random traffic concentrated on a few sets to force evictions
    task automatic queue_random(int n);
        logic [31:0] a;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            a = $urandom;
            if (r < 70) begin
                a[OFFB +: SETB] = $urandom_range(0, 3) == 0 ? sactc_pkg::SET_LAST
                                  : SETB'($urandom_range(0, 3));
                a[31 -: TAGW] = TAGW'($urandom_range(0, 23));
                if (r < 15) a[31 -: TAGW] = TAGW'($urandom);
            end
            if ($urandom_range(0, 4) == 0)
                a[OFFB-1:0] = OFFB'(sactc_pkg::LINE_BYTES - int'($urandom_range(1, 3)));
            pending_reqs.push_back(make_req(1'($urandom_range(0, 1)), a,
                                            3'($urandom_range(0, 7))));
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_valid || expected_rsps.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_seed(logic [LFW-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        victim_lfsr = v;
    endtask

    initial begin
        clear_cache(sactc_pkg::SEED_RESET);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, line crossings, wrap at top of memory
        pending_reqs.push_back(make_req(sactc_pkg::REQ_READ, 32'h0, 3'd0));
        pending_reqs.push_back(make_req(sactc_pkg::REQ_WRITE, 32'h0, 3'd1));
        pending_reqs.push_back(make_req(sactc_pkg::REQ_READ, 32'h0000_003F, 3'd4));
        pending_reqs.push_back(make_req(sactc_pkg::REQ_WRITE, 32'h0000_003D, 3'd7));
        pending_reqs.push_back(make_req(sactc_pkg::REQ_READ, 32'h0000_003D, 3'd3));
        pending_reqs.push_back(make_req(sactc_pkg::REQ_WRITE, 32'hFFFF_FFFF, 3'd2));
        pending_reqs.push_back(make_req(sactc_pkg::REQ_READ, 32'hFFFF_FFC0, 3'd5));
        pending_reqs.push_back(make_req(sactc_pkg::REQ_WRITE, 32'hAAAA_5555, 3'd6));
        pending_reqs.push_back(make_req(sactc_pkg::REQ_READ, 32'h5555_AAAA, 3'd4));
        // Put 18 distinct tags into one set (14 writes, then 4 reads) to overflow its 16 ways
        for (int i = 0; i < 18; i++)
            pending_reqs.push_back(make_req(i < 14 ? sactc_pkg::REQ_WRITE
                                                   : sactc_pkg::REQ_READ,
                                            {TAGW'(i), SETB'(5), 6'd0}, 3'd1));
        wait_drained();

        queue_random(500);
        wait_drained();
        write_seed(16'h0000);
        queue_random(300);
        wait_drained();
        write_seed(16'hFFFF);
        queue_random(400);
        wait_drained();
        write_seed(16'h0001);
        queue_random(300);
        wait_drained();
        write_seed(LFW'($urandom_range(1, 65535)));
        queue_random(300);
        stim_done = 1;
        wait_drained();

        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/sactc_pkg.sv
rtl/sactc_ctrl.sv
rtl/sactc_dp.sv
rtl/set_assoc_cache_tag_controller.sv
tb/set_assoc_cache_tag_controller_tb.sv
